>>> design/ptd_pkg.sv
// shared types and constants of the periodic task dispatcher
package ptd_pkg;

  localparam logic [1:0] MODE_TICK   = 2'd0;
  localparam logic [1:0] MODE_CREATE = 2'd1;
  localparam logic [1:0] MODE_DELETE = 2'd2;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_FULL      = 2'd1;
  localparam logic [1:0] ST_NOT_FOUND = 2'd2;

  typedef struct packed {
    logic [1:0]  mode;
    logic [7:0]  task_id;
    logic [15:0] period;
    logic [7:0]  start_time;
    logic [7:0]  priority_req;
  } cmd_t;

  typedef struct packed {
    logic [7:0]  id;
    logic [15:0] period;
    logic [7:0]  start;
    logic [7:0]  prio;
  } entry_t;

endpackage

>>> design/periodic_task_dispatcher_core.sv
// top level: command queue, task engine and result queue
// Each command enters a two-entry queue and is taken by the engine in the cycle after
// its push at the earliest; a create or delete walks the table. A tick walks it too,
// skipping tasks with a zero period and testing the others with the shared 16-step
// serial remainder unit, and gives one result for each released task.
// Results leave through a two-entry queue, so either side may stall; the engine waits
// while that queue is full.
module periodic_task_dispatcher_core #(
  parameter int TABLE_DEPTH = 8
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        push,
  output logic        full,
  input  logic [1:0]  in_mode,
  input  logic [7:0]  in_task_id,
  input  logic [15:0] in_period,
  input  logic [7:0]  in_start_time,
  input  logic [7:0]  in_priority_req,
  output logic        empty,
  input  logic        pop,
  output logic [1:0]  out_status,
  output logic        out_ready_valid,
  output logic [7:0]  out_ready_id,
  output logic        out_last
);
  ptd_pkg::cmd_t in_cmd, q_cmd, r_in, r_out;
  logic q_empty, take, rv, r_full, r_empty;
  logic [1:0] st; logic rvv, lst; logic [7:0] rid;

  assign in_cmd = '{mode: in_mode, task_id: in_task_id, period: in_period,
                    start_time: in_start_time, priority_req: in_priority_req};

  ptd_cmd_fifo u_in (
    .clk(clk), .rst_n(rst_n), .wr_en(push), .wr_data(in_cmd), .full(full),
    .rd_en(take), .rd_data(q_cmd), .empty(q_empty)
  );

  ptd_engine #(.TABLE_DEPTH(TABLE_DEPTH)) u_eng (
    .clk(clk), .rst_n(rst_n), .cmd_valid(!q_empty), .cmd(q_cmd), .cmd_take(take),
    .res_valid(rv), .res_full(r_full), .res_status(st), .res_ready_valid(rvv),
    .res_ready_id(rid), .res_last(lst)
  );

  assign r_in = '{mode: st, task_id: rid, period: {15'd0, rvv}, start_time: {7'd0, lst},
                  priority_req: 8'd0};

  ptd_cmd_fifo u_out (
    .clk(clk), .rst_n(rst_n), .wr_en(rv), .wr_data(r_in), .full(r_full),
    .rd_en(pop), .rd_data(r_out), .empty(r_empty)
  );

  assign empty           = r_empty;
  assign out_status      = r_out.mode;
  assign out_ready_id    = r_out.task_id;
  assign out_ready_valid = r_out.period[0];
  assign out_last        = r_out.start_time[0];
endmodule

>>> design/ptd_cmd_fifo.sv
// two-entry queue, used for commands into the task engine and for its results
module ptd_cmd_fifo (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          wr_en,
  input  ptd_pkg::cmd_t wr_data,
  output logic          full,
  input  logic          rd_en,
  output ptd_pkg::cmd_t rd_data,
  output logic          empty
);
  ptd_pkg::cmd_t mem_r [2];
  logic       wp_r, wp_nxt, rp_r, rp_nxt;
  logic [1:0] cnt_r, cnt_nxt;

  always_comb begin
    wp_nxt  = wp_r ^ (wr_en & ~full);
    rp_nxt  = rp_r ^ (rd_en & ~empty);
    cnt_nxt = cnt_r + {1'b0, wr_en & ~full} - {1'b0, rd_en & ~empty};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
    if (wr_en && !full) mem_r[wp_r] <= wr_data;
  end

  assign rd_data = mem_r[rp_r];
  assign full    = cnt_r == 2'd2;
  assign empty   = cnt_r == 2'd0;

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n) cnt_r <= 2'd2)
    else $error("queue count overflow");
  a_no_wrap: assert property (@(posedge clk) disable iff (!rst_n)
    full |=> !empty) else $error("full queue went empty");
  a_ptr_match: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r == 2'd0 || cnt_r == 2'd2) |-> wp_r == rp_r) else $error("pointer mismatch");
endmodule

>>> design/ptd_mod_unit.sv
// bit-serial remainder unit, one quotient bit per cycle
module ptd_mod_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [15:0] dividend,
  input  logic [15:0] divisor,
  output logic        done,
  output logic        zero_rem
);
  logic [15:0] q_r, q_nxt;
  logic [16:0] rem_r, rem_nxt;
  logic [15:0] div_r;
  logic [4:0]  cnt_r, cnt_nxt;
  logic        busy_r, busy_nxt;
  logic [16:0] sh;

  always_comb begin
    sh       = {rem_r[15:0], q_r[15]};
    rem_nxt  = rem_r;
    q_nxt    = q_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    if (start) begin
      rem_nxt  = 17'd0;
      q_nxt    = dividend;
      cnt_nxt  = 5'd16;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      rem_nxt = (sh >= {1'b0, div_r}) ? sh - {1'b0, div_r} : sh;
      q_nxt   = {q_r[14:0], 1'b0};
      cnt_nxt = cnt_r - 5'd1;
      if (cnt_r == 5'd1) busy_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= 5'd0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
    end
    rem_r <= rem_nxt;
    q_r   <= q_nxt;
    if (start) div_r <= divisor;
  end

  assign done     = busy_r && cnt_r == 5'd1;
  assign zero_rem = rem_nxt == 17'd0;
endmodule

>>> design/ptd_engine.sv
// task table and command engine: insert, delete and tick walks
module ptd_engine #(
  parameter int TABLE_DEPTH = 8
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          cmd_valid,
  input  ptd_pkg::cmd_t cmd,
  output logic          cmd_take,
  output logic          res_valid,
  input  logic          res_full,
  output logic [1:0]    res_status,
  output logic          res_ready_valid,
  output logic [7:0]    res_ready_id,
  output logic          res_last
);
  localparam int IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CW = $clog2(TABLE_DEPTH + 1);
  localparam logic [CW-1:0] DEPTH_C = CW'(TABLE_DEPTH);
  localparam logic [CW-1:0] ONE_C = CW'(1);

  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001, S_FIND = 7'b0000010, S_SHIFT = 7'b0000100,
    S_DEL  = 7'b0001000, S_TCHK = 7'b0010000, S_TWAIT = 7'b0100000,
    S_EMIT = 7'b1000000
  } state_t;

  state_t state_r, state_nxt;
  ptd_pkg::entry_t tab_r [TABLE_DEPTH];
  ptd_pkg::cmd_t   cmd_r, cmd_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt, idx_r, idx_nxt, pos_r, pos_nxt;
  logic [15:0]   tick_r, tick_nxt;
  logic          pend_r, pend_nxt;
  logic [7:0]    pid_r, pid_nxt;
  logic          wr_en, wr_shift_up, wr_shift_dn;
  ptd_pkg::entry_t cur, new_e;
  logic [15:0]   diff;
  logic          m_start, m_done, m_zero;

  assign cur   = tab_r[idx_r[IW-1:0]];
  assign new_e = '{id: cmd_r.task_id, period: cmd_r.period, start: cmd_r.start_time,
                   prio: cmd_r.priority_req};
  assign diff  = (tick_r >= {8'd0, cur.start}) ? tick_r - {8'd0, cur.start}
                                               : {8'd0, cur.start} - tick_r;

  ptd_mod_unit u_mod (
    .clk(clk), .rst_n(rst_n), .start(m_start), .dividend(diff),
    .divisor(cur.period), .done(m_done), .zero_rem(m_zero)
  );

  always_comb begin
    state_nxt = state_r;
    cmd_nxt = cmd_r; cnt_nxt = cnt_r; idx_nxt = idx_r; pos_nxt = pos_r;
    tick_nxt = tick_r; pend_nxt = pend_r; pid_nxt = pid_r;
    cmd_take = 1'b0; m_start = 1'b0;
    wr_en = 1'b0; wr_shift_up = 1'b0; wr_shift_dn = 1'b0;
    res_valid = 1'b0; res_status = ptd_pkg::ST_OK; res_ready_valid = 1'b0;
    res_ready_id = 8'd0; res_last = 1'b1;
    unique case (state_r)
      S_IDLE: if (cmd_valid && !res_full) begin
        cmd_take = 1'b1; cmd_nxt = cmd; idx_nxt = '0; pend_nxt = 1'b0;
        case (cmd.mode)
          ptd_pkg::MODE_TICK: begin
            tick_nxt = tick_r + 16'd1;
            state_nxt = S_TCHK;
          end
          ptd_pkg::MODE_CREATE:
            if (cnt_r >= DEPTH_C) begin
              res_valid = 1'b1; res_status = ptd_pkg::ST_FULL;
            end else state_nxt = S_FIND;
          ptd_pkg::MODE_DELETE: state_nxt = S_DEL;
          default: res_valid = 1'b1;
        endcase
      end
      S_FIND:
        if (idx_r < cnt_r && cur.prio >= cmd_r.priority_req) idx_nxt = idx_r + ONE_C;
        else begin
          pos_nxt = idx_r; idx_nxt = cnt_r; state_nxt = S_SHIFT;
        end
      S_SHIFT:
        if (idx_r > pos_r) begin
          wr_shift_up = 1'b1; idx_nxt = idx_r - ONE_C;
        end else begin
          wr_en = 1'b1; cnt_nxt = cnt_r + ONE_C; res_valid = 1'b1;
          state_nxt = S_IDLE;
        end
      S_DEL:
        if (pend_r) begin
          if (idx_r + ONE_C < cnt_r) begin
            wr_shift_dn = 1'b1; idx_nxt = idx_r + ONE_C;
          end else begin
            cnt_nxt = cnt_r - ONE_C; res_valid = 1'b1; pend_nxt = 1'b0;
            state_nxt = S_IDLE;
          end
        end else if (idx_r >= cnt_r) begin
          res_valid = 1'b1; res_status = ptd_pkg::ST_NOT_FOUND; state_nxt = S_IDLE;
        end else if (cur.id == cmd_r.task_id) pend_nxt = 1'b1;
        else idx_nxt = idx_r + ONE_C;
      S_TCHK:
        if (idx_r >= cnt_r) begin
          if (!res_full) begin
            res_valid = 1'b1;
            if (pend_r) begin
              res_ready_valid = 1'b1; res_ready_id = pid_r;
            end
            state_nxt = S_IDLE;
          end
        end else if (cur.period == 16'd0) idx_nxt = idx_r + ONE_C;
        else begin
          m_start = 1'b1; state_nxt = S_TWAIT;
        end
      S_TWAIT:
        if (m_done) state_nxt = m_zero ? S_EMIT : S_TCHK;
        else state_nxt = S_TWAIT;
      S_EMIT:
        if (!pend_r) begin
          pend_nxt = 1'b1; pid_nxt = cur.id; idx_nxt = idx_r + ONE_C; state_nxt = S_TCHK;
        end else if (!res_full) begin
          res_valid = 1'b1; res_ready_valid = 1'b1; res_ready_id = pid_r; res_last = 1'b0;
          pid_nxt = cur.id; idx_nxt = idx_r + ONE_C; state_nxt = S_TCHK;
        end
      default: state_nxt = S_IDLE;
    endcase
    if (state_r == S_TWAIT && m_done && !m_zero) idx_nxt = idx_r + ONE_C;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE; cnt_r <= '0; tick_r <= 16'd0; pend_r <= 1'b0;
    end else begin
      state_r <= state_nxt; cnt_r <= cnt_nxt; tick_r <= tick_nxt; pend_r <= pend_nxt;
    end
    cmd_r <= cmd_nxt; idx_r <= idx_nxt; pos_r <= pos_nxt;
    pid_r <= pid_nxt;
    if (wr_shift_up) tab_r[idx_r[IW-1:0]] <= tab_r[IW'(idx_r - ONE_C)];
    if (wr_shift_dn) tab_r[idx_r[IW-1:0]] <= tab_r[IW'(idx_r + ONE_C)];
    if (wr_en) tab_r[pos_r[IW-1:0]] <= new_e;
  end

  a_cnt: assert property (@(posedge clk) disable iff (!rst_n) cnt_r <= DEPTH_C)
    else $error("task count above depth");
  a_full_drop: assert property (@(posedge clk) disable iff (!rst_n)
    (res_valid && res_status == ptd_pkg::ST_FULL) |-> cnt_r == DEPTH_C)
    else $error("full status with room");
  a_tick_res: assert property (@(posedge clk) disable iff (!rst_n)
    (res_valid && res_ready_valid) |-> res_status == ptd_pkg::ST_OK)
    else $error("dispatch with error status");
endmodule
